>>> design/ifst_pkg.sv
// ----------------------------------------------------------------------------
// ifst_pkg: shared types and constants of the fragment steering table
// Holds table sizes, action codes, controller states and the command and
// status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package ifst_pkg;

  localparam int FILTER_ENTRIES = 16;
  localparam int PARK_ENTRIES   = 32;
  localparam int FIDX_W = $clog2(FILTER_ENTRIES);
  localparam int PIDX_W = $clog2(PARK_ENTRIES);

  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [13:0] LEN_ID    = 14'd20;
  localparam logic [13:0] LEN_FRAG  = 14'd21;
  localparam logic [7:0]  MF_BIT    = 8'h20;
  localparam logic [7:0]  OFS_HI_M  = 8'h1F;
  localparam logic [3:0]  AGE_MAX   = 4'd15;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_DELIVER = 2'd1,
    ACT_PARKED  = 2'd2,
    ACT_DROPPED = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_DRAIN,
    ST_EMIT,
    ST_FINISH
  } state_t;

  // Frame classes decided at acceptance.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FIRST,
    KIND_MIDDLE,
    KIND_OTHER
  } kind_t;

  typedef struct packed {
    logic capture;      // latch the input item
    logic head_commit;  // apply the table update of the head result
    logic head_load;    // load the head result into the output register
    logic drain_step;   // examine one park slot
    logic drain_load;   // load the matching park slot as a result
    logic drain_finish; // write the compacted valid bits back
    logic set_last;     // mark the loaded result as the last one
  } cmd_t;

  typedef struct packed {
    logic  start_drain; // head is a delivered first fragment with parked matches
    logic  drain_hit;   // current park slot matches the id
    logic  drain_last;  // no park slot after the current one matches the id
    logic  drain_end;   // current park slot is the final one
  } stat_t;

endpackage
`default_nettype wire

>>> design/ifst_ctrl.sv
// ----------------------------------------------------------------------------
// ifst_ctrl: controller of the fragment steering table
// Sequences capture, head decision, park drain and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module ifst_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire ifst_pkg::stat_t st,
  output ifst_pkg::cmd_t      cmd
);
  import ifst_pkg::*;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ov_r       <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

  always_comb begin
    logic free;
    free = !ov_r || !out_stall;
    state_nxt    = state_r;
    ov_nxt       = ov_r && out_stall;
    cmd          = '0;
    in_stall     = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (free) begin
          cmd.head_commit = 1'b1;
          cmd.head_load   = 1'b1;
          ov_nxt          = 1'b1;
          if (st.start_drain) begin
            state_nxt = ST_DRAIN;
          end else begin
            cmd.set_last = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DRAIN: begin
        // One park slot per cycle; a match waits for the output register.
        if (st.drain_hit) begin
          if (free) begin
            cmd.drain_step = 1'b1;
            cmd.drain_load = 1'b1;
            cmd.set_last   = st.drain_last;
            ov_nxt = 1'b1;
            if (st.drain_end) begin
              cmd.drain_finish = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          cmd.drain_step = 1'b1;
          if (st.drain_end) begin
            // The last result already carries its flag; only the compacted
            // valid bits remain to be written.
            cmd.drain_finish = 1'b1;
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> design/ifst_dp.sv
// ----------------------------------------------------------------------------
// ifst_dp: datapath of the fragment steering table
// Holds the filter table, the park store, the captured item and the result
// register. A look-ahead over the remaining park slots tells which drained
// result is the final one.
// ----------------------------------------------------------------------------
`default_nettype none
module ifst_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ifst_pkg::cmd_t cmd,
  output ifst_pkg::stat_t     st,
  input  wire logic [15:0]    in_ethertype,
  input  wire logic [15:0]    in_ip_id,
  input  wire logic [7:0]     in_frag_hi,
  input  wire logic [7:0]     in_frag_lo,
  input  wire logic [13:0]    in_frame_len,
  input  wire logic           in_class_hit,
  input  wire logic [15:0]    in_class_buffer,
  input  wire logic [15:0]    in_pkt_handle,
  input  wire logic [15:0]    in_rx_flags,
  output logic [1:0]          out_action,
  output logic [15:0]         out_dest_buffer,
  output logic [15:0]         out_out_handle,
  output logic [15:0]         out_out_flags,
  output logic                out_from_park,
  output logic                out_last
);
  import ifst_pkg::*;

  logic [FILTER_ENTRIES-1:0] fv_r;
  logic [15:0]               fid_r  [FILTER_ENTRIES];
  logic [15:0]               fbuf_r [FILTER_ENTRIES];
  logic [3:0]                fage_r [FILTER_ENTRIES];
  logic [PARK_ENTRIES-1:0]   pv_r;
  logic [15:0]               pid_r  [PARK_ENTRIES];
  logic [15:0]               ph_r   [PARK_ENTRIES];
  logic [15:0]               pf_r   [PARK_ENTRIES];

  kind_t       kind_r;
  logic [15:0] id_r, cbuf_r, h_r, f_r;
  logic        hit_r;
  logic [PIDX_W-1:0] pi_r;
  logic [PIDX_W:0]   pw_r;

  // Captured frame classification.
  logic [15:0] eff_id;
  logic        frag, first;
  always_comb begin
    eff_id = (in_frame_len < LEN_ID) ? 16'd0 : in_ip_id;
    frag   = (in_frame_len > LEN_ID) && (in_ethertype == ETH_IPV4) &&
             ((in_frag_hi & MF_BIT) != 8'd0);
    first  = frag && (in_frame_len > LEN_FRAG) &&
             (((in_frag_hi & OFS_HI_M) | in_frag_lo) == 8'd0);
  end

  // Newest matching filter: priority search over the valid bits.
  logic              fmatch;
  logic [FIDX_W-1:0] fat;
  always_comb begin
    fmatch = 1'b0;
    fat    = '0;
    for (int i = FILTER_ENTRIES - 1; i >= 0; i--) begin
      if (fv_r[i] && fid_r[i] == id_r) begin
        fmatch = 1'b1;
        fat    = FIDX_W'(i);
      end
    end
  end

  // Head decision.
  act_t        hact;
  logic [15:0] hdest;
  logic        do_fins, do_frem, do_park;
  always_comb begin
    hact = ACT_NONE; hdest = 16'd0;
    do_fins = 1'b0; do_frem = 1'b0; do_park = 1'b0;
    case (kind_r)
      KIND_FIRST: begin
        if (!hit_r || fv_r[FILTER_ENTRIES-1]) begin
          hact = ACT_DROPPED;
        end else begin
          hact = ACT_DELIVER; hdest = cbuf_r; do_fins = 1'b1;
        end
      end
      KIND_MIDDLE: begin
        if (fmatch) begin
          hact = ACT_DELIVER; hdest = fbuf_r[fat];
        end else if (pv_r[PARK_ENTRIES-1]) begin
          hact = ACT_DROPPED;
        end else begin
          hact = ACT_PARKED; do_park = 1'b1;
        end
      end
      KIND_OTHER: begin
        if (fmatch) begin
          hact = ACT_DELIVER; hdest = fbuf_r[fat]; do_frem = 1'b1;
        end
      end
      default: hact = ACT_NONE;
    endcase
  end

  // Park slots holding the captured id, and those after the current slot.
  logic [PARK_ENTRIES-1:0] pmv, plater;
  always_comb begin
    for (int i = 0; i < PARK_ENTRIES; i++) pmv[i] = pv_r[i] && (pid_r[i] == id_r);
    plater = (pmv >> pi_r) >> 1;
  end

  logic pmatch;
  assign pmatch = pmv[pi_r];
  assign st.start_drain = do_fins && (|pmv);
  assign st.drain_hit   = pmatch;
  assign st.drain_last  = ~|plater;
  assign st.drain_end   = (pi_r == PIDX_W'(PARK_ENTRIES - 1));

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      id_r   <= eff_id;
      cbuf_r <= in_class_buffer;
      h_r    <= in_pkt_handle;
      f_r    <= in_rx_flags;
      hit_r  <= in_class_hit;
      if (eff_id == 16'd0) kind_r <= KIND_NONE;
      else if (first)      kind_r <= KIND_FIRST;
      else if (frag)       kind_r <= KIND_MIDDLE;
      else                 kind_r <= KIND_OTHER;
    end
  end

  // Filter table: shift on insert, shift down on removal.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
      for (int i = 0; i < FILTER_ENTRIES; i++) fage_r[i] <= 4'd0;
    end else if (cmd.head_commit && do_fins) begin
      for (int i = FILTER_ENTRIES - 1; i > 0; i--) begin
        fv_r[i]   <= fv_r[i-1];
        fid_r[i]  <= fid_r[i-1];
        fbuf_r[i] <= fbuf_r[i-1];
        fage_r[i] <= (fage_r[i-1] < AGE_MAX) ? fage_r[i-1] + 4'd1 : AGE_MAX;
      end
      fv_r[0] <= 1'b1; fid_r[0] <= id_r; fbuf_r[0] <= cbuf_r; fage_r[0] <= 4'd0;
    end else if (cmd.head_commit && do_frem) begin
      for (int i = 0; i < FILTER_ENTRIES - 1; i++) begin
        if (FIDX_W'(i) >= fat) begin
          fv_r[i]   <= fv_r[i+1];
          fid_r[i]  <= fid_r[i+1];
          fbuf_r[i] <= fbuf_r[i+1];
          fage_r[i] <= fage_r[i+1];
        end
      end
      fv_r[FILTER_ENTRIES-1]   <= 1'b0;
      fage_r[FILTER_ENTRIES-1] <= 4'd0;
    end
  end

  // Park store: shift-in on park, in-place compaction during drain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
      pi_r <= '0;
      pw_r <= '0;
    end else if (cmd.head_commit && do_park) begin
      for (int i = PARK_ENTRIES - 1; i > 0; i--) begin
        pv_r[i] <= pv_r[i-1]; pid_r[i] <= pid_r[i-1];
        ph_r[i] <= ph_r[i-1]; pf_r[i]  <= pf_r[i-1];
      end
      pv_r[0] <= 1'b1; pid_r[0] <= id_r; ph_r[0] <= h_r; pf_r[0] <= f_r;
    end else if (cmd.head_commit && do_fins) begin
      pi_r <= '0;
      pw_r <= '0;
    end else if (cmd.drain_step) begin
      // Write index never passes read index, so compaction is in place.
      if (pv_r[pi_r] && !pmatch) begin
        pid_r[pw_r[PIDX_W-1:0]] <= pid_r[pi_r];
        ph_r[pw_r[PIDX_W-1:0]]  <= ph_r[pi_r];
        pf_r[pw_r[PIDX_W-1:0]]  <= pf_r[pi_r];
        pw_r <= pw_r + (PIDX_W+1)'(1);
      end
      pi_r <= pi_r + PIDX_W'(1);
      if (cmd.drain_finish) begin
        for (int i = 0; i < PARK_ENTRIES; i++) begin
          pv_r[i] <= ((PIDX_W+1)'(i) < pw_r + (PIDX_W+1)'(pv_r[pi_r] && !pmatch));
        end
      end
    end
  end

  // Result register. A drained result overwrites nothing still unsent: the
  // controller loads only when the register is free, with the last flag
  // already known from the look-ahead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_last <= 1'b0;
    end else if (cmd.head_load) begin
      out_action      <= hact;
      out_dest_buffer <= hdest;
      out_out_handle  <= h_r;
      out_out_flags   <= f_r;
      out_from_park   <= 1'b0;
      out_last        <= cmd.set_last;
    end else if (cmd.drain_load) begin
      out_action      <= ACT_DELIVER;
      out_dest_buffer <= cbuf_r;
      out_out_handle  <= ph_r[pi_r];
      out_out_flags   <= pf_r[pi_r];
      out_from_park   <= 1'b1;
      out_last        <= cmd.set_last;
    end
  end

endmodule
`default_nettype wire

>>> design/ip_fragment_steering_table.sv
// ----------------------------------------------------------------------------
// ip_fragment_steering_table: IPv4 fragment steering
// Steers received frames by fragment class using a filter table and a park
// store for fragments that arrive ahead of their first fragment.
// ----------------------------------------------------------------------------
// Usage: the input channel takes the header fields of one frame as an item
// when in_valid is high and in_stall is low. The block works on one frame at
// a time and holds in_stall high until its results are issued.
// Each frame gives one head result, and a delivered first fragment also
// gives one result per parked fragment of its id, newest first; out_last
// marks the final result of a frame.
// Timing: the head result is loaded into the output register in the HEAD
// state, once that register is free. A first fragment with parked fragments
// of its id then walks the park store, one slot per cycle while no matching
// slot waits for the output register, and this drain walk makes such frames
// the longest ones.
// When the receiver stalls, the result register holds and the walk waits
// on a matching slot. Reset empties both tables at once through their
// valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module ip_fragment_steering_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_ethertype,
  input  wire logic [15:0] in_ip_id,
  input  wire logic [7:0]  in_frag_hi,
  input  wire logic [7:0]  in_frag_lo,
  input  wire logic [13:0] in_frame_len,
  input  wire logic        in_class_hit,
  input  wire logic [15:0] in_class_buffer,
  input  wire logic [15:0] in_pkt_handle,
  input  wire logic [15:0] in_rx_flags,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_action,
  output logic [15:0]      out_dest_buffer,
  output logic [15:0]      out_out_handle,
  output logic [15:0]      out_out_flags,
  output logic             out_from_park,
  output logic             out_last
);
  import ifst_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // The controller sequences the frame; the datapath owns every table.
  ifst_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .st, .cmd
  );

  ifst_dp u_dp (
    .clk, .rst_n, .cmd, .st,
    .in_ethertype, .in_ip_id, .in_frag_hi, .in_frag_lo, .in_frame_len,
    .in_class_hit, .in_class_buffer, .in_pkt_handle, .in_rx_flags,
    .out_action, .out_dest_buffer, .out_out_handle, .out_out_flags,
    .out_from_park, .out_last
  );

`ifndef NO_ASSERTIONS
  // A drained result is always a delivery.
  a_park_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_from_park |-> out_action == ACT_DELIVER)
    else $error("drained result is not a delivery");
  // Undelivered results carry no destination buffer.
  a_dest_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != ACT_DELIVER |-> out_dest_buffer == 16'd0)
    else $error("destination set on non-delivery");
  // No item is taken while a frame is still at work.
  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted during a frame");
`endif

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the IP fragment steering table
// Drives frame header items through a queue-fed driver, predicts the steering
// results with a behavioral copy of the filter table and park store, and
// checks every result field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import ifst_pkg::*;

  // One frame header as it enters the block.
  typedef struct packed {
    logic [15:0] ethertype;
    logic [15:0] ip_id;
    logic [7:0]  frag_hi;
    logic [7:0]  frag_lo;
    logic [13:0] frame_len;
    logic        class_hit;
    logic [15:0] class_buffer;
    logic [15:0] pkt_handle;
    logic [15:0] rx_flags;
  } frame_t;

  // One steering result.
  typedef struct packed {
    act_t        action;
    logic [15:0] dest_buffer;
    logic [15:0] handle;
    logic [15:0] flags;
    logic        from_park;
    logic        last;
  } steer_t;

  localparam int LIMIT_CYCLES = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  frame_t in_frame;
  logic out_valid;
  logic out_stall;
  logic [1:0] out_action;
  logic [15:0] out_dest_buffer;
  logic [15:0] out_out_handle;
  logic [15:0] out_out_flags;
  logic out_from_park;
  logic out_last;

  ip_fragment_steering_table uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_ethertype(in_frame.ethertype),
    .in_ip_id(in_frame.ip_id),
    .in_frag_hi(in_frame.frag_hi),
    .in_frag_lo(in_frame.frag_lo),
    .in_frame_len(in_frame.frame_len),
    .in_class_hit(in_frame.class_hit),
    .in_class_buffer(in_frame.class_buffer),
    .in_pkt_handle(in_frame.pkt_handle),
    .in_rx_flags(in_frame.rx_flags),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_action(out_action),
    .out_dest_buffer(out_dest_buffer),
    .out_out_handle(out_out_handle),
    .out_out_flags(out_out_flags),
    .out_from_park(out_from_park),
    .out_last(out_last)
  );

  // Behavioral copy of the block's tables. Entry 0 is the newest in both.
  logic        flt_valid [FILTER_ENTRIES];
  logic [15:0] flt_id    [FILTER_ENTRIES];
  logic [15:0] flt_buf   [FILTER_ENTRIES];
  logic        prk_valid [PARK_ENTRIES];
  logic [15:0] prk_id    [PARK_ENTRIES];
  logic [15:0] prk_handle[PARK_ENTRIES];
  logic [15:0] prk_flags [PARK_ENTRIES];

  frame_t pending_frames[$];
  steer_t expected_results[$];
  int     mismatches;
  int     cycle_count;
  int     send_idle_pct;
  int     recv_idle_pct;
  logic   hold_send;
  logic   in_taken;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  function automatic steer_t make_result(act_t act, logic [15:0] dest, logic [15:0] h,
                                         logic [15:0] f, logic fp);
    steer_t r;
    r.action = act;
    r.dest_buffer = dest;
    r.handle = h;
    r.flags = f;
    r.from_park = fp;
    r.last = 1'b0;
    return r;
  endfunction

  // Newest valid filter holding this id, or -1.
  function automatic int find_filter(logic [15:0] id);
    for (int i = 0; i < FILTER_ENTRIES; i++)
      if (flt_valid[i] && flt_id[i] == id) return i;
    return -1;
  endfunction

  // Works out the results of one accepted frame and updates the tables.
  task automatic predict_steering(input frame_t fr);
    logic [15:0] id;
    logic is_frag;
    logic is_first;
    int at;
    int w;
    steer_t r;
    id = (fr.frame_len < LEN_ID) ? 16'd0 : fr.ip_id;
    is_frag = fr.frame_len > LEN_ID && fr.ethertype == ETH_IPV4 && (fr.frag_hi & MF_BIT) != 0;
    is_first = is_frag && fr.frame_len > LEN_FRAG &&
               ((fr.frag_hi & OFS_HI_M) | fr.frag_lo) == 8'd0;
    if (id == 16'd0) begin
      expected_results.push_back(make_result(ACT_NONE, 0, fr.pkt_handle, fr.rx_flags, 0));
    end else if (is_first) begin
      if (!fr.class_hit || flt_valid[FILTER_ENTRIES-1]) begin
        expected_results.push_back(make_result(ACT_DROPPED, 0, fr.pkt_handle, fr.rx_flags, 0));
      end else begin
        for (int i = FILTER_ENTRIES - 1; i > 0; i--) begin
          flt_valid[i] = flt_valid[i-1];
          flt_id[i] = flt_id[i-1];
          flt_buf[i] = flt_buf[i-1];
        end
        flt_valid[0] = 1'b1;
        flt_id[0] = id;
        flt_buf[0] = fr.class_buffer;
        expected_results.push_back(make_result(ACT_DELIVER, fr.class_buffer, fr.pkt_handle,
                                               fr.rx_flags, 0));
        // Drain parked fragments of this id, newest first, and compact the rest.
        w = 0;
        for (int i = 0; i < PARK_ENTRIES; i++) begin
          if (prk_valid[i]) begin
            if (prk_id[i] == id) begin
              expected_results.push_back(make_result(ACT_DELIVER, fr.class_buffer,
                                                     prk_handle[i], prk_flags[i], 1));
            end else begin
              prk_valid[w] = 1'b1;
              prk_id[w] = prk_id[i];
              prk_handle[w] = prk_handle[i];
              prk_flags[w] = prk_flags[i];
              w++;
            end
          end
        end
        for (int i = w; i < PARK_ENTRIES; i++) prk_valid[i] = 1'b0;
      end
    end else if (is_frag) begin
      at = find_filter(id);
      if (at >= 0) begin
        expected_results.push_back(make_result(ACT_DELIVER, flt_buf[at], fr.pkt_handle,
                                               fr.rx_flags, 0));
      end else if (prk_valid[PARK_ENTRIES-1]) begin
        expected_results.push_back(make_result(ACT_DROPPED, 0, fr.pkt_handle, fr.rx_flags, 0));
      end else begin
        for (int i = PARK_ENTRIES - 1; i > 0; i--) begin
          prk_valid[i] = prk_valid[i-1];
          prk_id[i] = prk_id[i-1];
          prk_handle[i] = prk_handle[i-1];
          prk_flags[i] = prk_flags[i-1];
        end
        prk_valid[0] = 1'b1;
        prk_id[0] = id;
        prk_handle[0] = fr.pkt_handle;
        prk_flags[0] = fr.rx_flags;
        expected_results.push_back(make_result(ACT_PARKED, 0, fr.pkt_handle, fr.rx_flags, 0));
      end
    end else begin
      at = find_filter(id);
      if (at >= 0) begin
        expected_results.push_back(make_result(ACT_DELIVER, flt_buf[at], fr.pkt_handle,
                                               fr.rx_flags, 0));
        // Only the matched entry is unlinked; the entries after it shift down by one.
        for (int i = at; i < FILTER_ENTRIES - 1; i++) begin
          flt_valid[i] = flt_valid[i+1];
          flt_id[i] = flt_id[i+1];
          flt_buf[i] = flt_buf[i+1];
        end
        flt_valid[FILTER_ENTRIES-1] = 1'b0;
      end else begin
        expected_results.push_back(make_result(ACT_NONE, 0, fr.pkt_handle, fr.rx_flags, 0));
      end
    end
    r = expected_results.pop_back();
    r.last = 1'b1;
    expected_results.push_back(r);
  endtask

  // Builds one frame of a given class. Kinds: 0 first, 1 middle, 2 last, 3 noise.
  function automatic frame_t make_frame(int kind, logic [15:0] id);
    frame_t fr;
    fr.ethertype = ETH_IPV4;
    fr.ip_id = id;
    fr.frame_len = 14'($urandom_range(22, 16383));
    fr.class_hit = 1'b1;
    fr.class_buffer = 16'($urandom);
    fr.pkt_handle = 16'($urandom);
    fr.rx_flags = 16'($urandom);
    fr.frag_hi = 8'($urandom) & 8'hC0;
    fr.frag_lo = 8'h00;
    case (kind)
      0: begin
        fr.frag_hi |= MF_BIT;
        if ($urandom_range(0, 9) == 0) fr.class_hit = 1'b0;
      end
      1: begin
        fr.frag_hi = 8'($urandom) | MF_BIT;
        fr.frag_lo = 8'($urandom);
        if ((fr.frag_hi & OFS_HI_M) == 0 && fr.frag_lo == 0) fr.frag_lo = 8'h01;
      end
      2: begin
        fr.frag_hi = 8'($urandom) & ~MF_BIT;
        fr.frag_lo = 8'($urandom);
      end
      default: begin
        fr = frame_t'({$urandom, $urandom, $urandom, $urandom});
        fr.frame_len = 14'($urandom_range(0, 40));
      end
    endcase
    return fr;
  endfunction

  // Driver: inputs change on the falling edge, an item leaves on acceptance.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_frames.size() > 0 && !hold_send &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_frame <= pending_frames.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Monitor: predicts on input acceptance and checks on output acceptance.
  always @(posedge clk) begin
    steer_t want;
    cycle_count <= cycle_count + 1;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) predict_steering(in_frame);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report("unexpected result, action", out_action, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_action != want.action) report("action", out_action, want.action);
        if (out_dest_buffer != want.dest_buffer)
          report("dest_buffer", out_dest_buffer, want.dest_buffer);
        if (out_out_handle != want.handle) report("handle", out_out_handle, want.handle);
        if (out_out_flags != want.flags) report("flags", out_out_flags, want.flags);
        if (out_from_park != want.from_park)
          report("from_park", out_from_park, want.from_park);
        if (out_last != want.last) report("last", out_last, want.last);
      end
    end
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_frames.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    frame_t fr;
    logic [15:0] ids[8];
    int kind;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_taken = 1'b0;
    in_frame = '0;
    out_stall = 1'b0;
    hold_send = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    send_idle_pct = 27;
    recv_idle_pct = 76;
    for (int i = 0; i < FILTER_ENTRIES; i++) flt_valid[i] = 1'b0;
    for (int i = 0; i < PARK_ENTRIES; i++) prk_valid[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: header length edges, zero id, non-IPv4 and all extremes.
    fr = make_frame(2, 16'h1234); fr.frame_len = 14'd19; pending_frames.push_back(fr);
    fr = make_frame(1, 16'h0000); pending_frames.push_back(fr);
    fr = make_frame(1, 16'hFFFF); fr.frame_len = 14'd20; pending_frames.push_back(fr);
    fr = make_frame(1, 16'hFFFF); fr.frame_len = 14'd21; fr.frag_hi = 8'hFF;
    fr.frag_lo = 8'hFF; fr.pkt_handle = 16'hFFFF; fr.rx_flags = 16'hFFFF;
    pending_frames.push_back(fr);
    fr = make_frame(0, 16'hFFFF); fr.frame_len = 14'd21; fr.frag_lo = 8'h00;
    pending_frames.push_back(fr);  // offset zero but too short: middle, parks
    fr = make_frame(1, 16'hFFFF); fr.ethertype = 16'hFFFF; pending_frames.push_back(fr);
    fr = make_frame(0, 16'hFFFF); fr.frame_len = 14'h3FFF; fr.class_hit = 1'b0;
    pending_frames.push_back(fr);
    fr = make_frame(0, 16'hFFFF); fr.class_buffer = 16'hFFFF; pending_frames.push_back(fr);
    fr = make_frame(1, 16'hFFFF); pending_frames.push_back(fr);
    fr = make_frame(0, 16'hFFFF); fr.class_buffer = 16'h0000; pending_frames.push_back(fr);
    fr = make_frame(1, 16'hFFFF); pending_frames.push_back(fr);
    fr = make_frame(2, 16'hFFFF); pending_frames.push_back(fr);  // newest duplicate goes
    fr = make_frame(2, 16'hFFFF); pending_frames.push_back(fr);
    fr = make_frame(2, 16'hFFFF); pending_frames.push_back(fr);  // no filter left
    // Fill the filter table to overflow so a first fragment is dropped.
    for (int i = 0; i < FILTER_ENTRIES + 1; i++)
      pending_frames.push_back(make_frame(0, 16'h0100 + 16'(i)));
    // Fill the park store past full so a middle fragment is dropped.
    for (int i = 0; i < PARK_ENTRIES + 1; i++)
      pending_frames.push_back(make_frame(1, 16'h0200 + 16'(i % 3)));
    wait_drained();

    // The sender is held off here by hold_send once every expected result has come.
    hold_send = 1'b1;
    repeat (4) @(posedge clk);
    hold_send = 1'b0;
    // Clear the filters so random first fragments are accepted again.
    for (int i = 0; i < FILTER_ENTRIES + 1; i++)
      pending_frames.push_back(make_frame(2, 16'h0100 + 16'(i)));
    // Deliver first fragments of the three parked ids, which drain the full park store.
    pending_frames.push_back(make_frame(0, 16'h0201));
    pending_frames.push_back(make_frame(0, 16'h0200));
    pending_frames.push_back(make_frame(0, 16'h0202));
    for (int i = 0; i < 3; i++) pending_frames.push_back(make_frame(2, 16'h0200 + 16'(i)));
    wait_drained();

    // Random part in three idling phases, mostly well-formed fragment trains.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 76 : 0;
      recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 27 : 0;
      for (int i = 0; i < 8; i++) ids[i] = 16'($urandom_range(1, 65535));
      for (int n = 0; n < 8; n++) begin
        kind = $urandom_range(0, 9);
        kind = (kind < 3) ? 1 : (kind < 5) ? 0 : (kind < 8) ? 2 : 3;
        fr = make_frame(kind, ids[$urandom_range(0, 7)]);
        pending_frames.push_back(fr);
      end
      wait_drained();
    end

    repeat (PARK_ENTRIES + 10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
design/ifst_pkg.sv
design/ifst_ctrl.sv
design/ifst_dp.sv
design/ip_fragment_steering_table.sv
sim/tb_top.sv
